// File: rtl/core/ecal_pkg.sv
package ecal_pkg;

	localparam int MAX_YEAR_DEF = 9999;

	// register stages from accepted word to result
	localparam int NUM_STG = 15;

	// day count from 0000-01-01 and second of day, as handed to the back end
	localparam int DAYS_W = 22;
	localparam int SOD_W  = 17;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [2:0]  weekday;
		logic [8:0]  day_of_year;
	} date_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tod_t;

endpackage

// File: rtl/core/ecal_tod.sv
module ecal_tod import ecal_pkg::*; (
	input  logic             clk,
	input  logic             adv,
	input  logic [SOD_W-1:0] sod,
	output tod_t             tod
);

	localparam int TOD_DONE = 7;

	// reciprocals rounded up, exact for every value of the operand width
	localparam logic [17:0] R_SOD60 = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
	localparam logic [11:0] R_MIN60 = 12'(((64'd1 << 17) + 64'd59) / 64'd60);

	logic [34:0]      p60_s4;
	logic [SOD_W-1:0] sod_s4;
	logic [10:0]      mt_s5;
	logic [5:0]       sec_s5;
	logic [22:0]      ph_s6;
	logic [10:0]      mt_s6;
	logic [5:0]       sec_s6;
	tod_t             tod_s [TOD_DONE:NUM_STG];

	always_ff @(posedge clk) begin
		if (adv) begin
			p60_s4 <= sod * R_SOD60;
			sod_s4 <= sod;

			// minutes of day, then seconds left over
			mt_s5  <= p60_s4[33:23];
			sec_s5 <= 6'(sod_s4 - 17'(p60_s4[33:23]) * 17'd60);

			ph_s6  <= mt_s5 * R_MIN60;
			mt_s6  <= mt_s5;
			sec_s6 <= sec_s5;

			tod_s[TOD_DONE].hour   <= ph_s6[21:17];
			tod_s[TOD_DONE].minute <= 6'(mt_s6 - 11'(ph_s6[21:17]) * 11'd60);
			tod_s[TOD_DONE].second <= sec_s6;
		end
	end

	// time of day is ready early, hold it in step with the date
	for (genvar i = TOD_DONE + 1; i <= NUM_STG; i++) begin : g_dly
		always_ff @(posedge clk) begin
			if (adv) begin
				tod_s[i] <= tod_s[i-1];
			end
		end
	end

	assign tod = tod_s[NUM_STG];

endmodule

// File: rtl/core/ecal_date.sv
module ecal_date import ecal_pkg::*; (
	input  logic              clk,
	input  logic              adv,
	input  logic [DAYS_W-1:0] days,
	output date_t             date
);

	// day count moved so that it starts one 400-year era before 0000-03-01
	localparam logic [21:0] ERA_SHIFT = 22'd146037;
	localparam logic [22:0] ERA_DAYS  = 23'd146097;
	// 0000-01-01 falls on a saturday
	localparam logic [22:0] WD_SHIFT  = 23'd6;
	localparam logic [3:0]  MP_JAN    = 4'd10;

	localparam logic [22:0] R_ERA    = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
	localparam logic [23:0] R_7      = 24'(((64'd1 << 26) + 64'd6) / 64'd7);
	localparam logic [18:0] R_1460   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam logic [18:0] R_36524  = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
	localparam logic [18:0] R_146096 = 19'(((64'd1 << 36) + 64'd146095) / 64'd146096);
	localparam logic [18:0] R_365    = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam logic [9:0]  R_100    = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
	localparam logic [12:0] R_153    = 13'(((64'd1 << 20) + 64'd152) / 64'd153);

	// first day of each march-based month within the march-based year
	function automatic logic [8:0] mstart(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	logic [21:0] z_s4;
	logic [22:0] wx_s4;
	logic [44:0] pera_s5;
	logic [21:0] z_s5;
	logic [46:0] pwd_s5;
	logic [22:0] wx_s5;
	logic [4:0]  era_s6, era_s7, era_s8, era_s9, era_s10, era_s11, era_s12, era_s13, era_s14;
	logic [2:0]  wd_s6, wd_s7, wd_s8, wd_s9, wd_s10, wd_s11, wd_s12, wd_s13, wd_s14;
	logic [17:0] doe_s6, doe_s7, doe_s8, doe_s9, doe_s10, doe_s11;
	logic [36:0] p1460_s7, p36524_s7, p146096_s7;
	logic [17:0] t_s8;
	logic [36:0] p365_s9;
	logic [8:0]  yoe_s10, yoe_s11, yoe_s12, yoe_s13, yoe_s14;
	logic [18:0] p100_s11;
	logic [17:0] y365_s11;
	logic [8:0]  doy_s12, doy_s13, doy_s14;
	logic [24:0] pmp_s13;
	logic [3:0]  mp_s14;
	date_t       date_s15;

	logic [4:0]  era_n;
	logic [20:0] q7_n;
	logic        jf_n;
	logic        leap_n;

	always_comb begin
		era_n  = pera_s5[44:40];
		q7_n   = pwd_s5[46:26];
		jf_n   = (mp_s14 >= MP_JAN);
		// a year of the era is leap when a multiple of 4 but not a century, or the era start
		leap_n = (yoe_s14[1:0] == 2'd0) && (yoe_s14 != 9'd100) && (yoe_s14 != 9'd200)
			&& (yoe_s14 != 9'd300);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s4  <= days + ERA_SHIFT;
			wx_s4 <= 23'(days) + WD_SHIFT;

			pera_s5 <= z_s4 * R_ERA;
			z_s5    <= z_s4;
			pwd_s5  <= wx_s4 * R_7;
			wx_s5   <= wx_s4;

			era_s6 <= era_n;
			doe_s6 <= 18'({1'b0, z_s5} - 23'(era_n) * ERA_DAYS);
			wd_s6  <= 3'(wx_s5 - 23'(q7_n) * 23'd7);

			p1460_s7   <= doe_s6 * R_1460;
			p36524_s7  <= doe_s6 * R_36524;
			p146096_s7 <= doe_s6 * R_146096;
			doe_s7     <= doe_s6;
			era_s7     <= era_s6;
			wd_s7      <= wd_s6;

			// take out the leap days so that every year counts 365
			t_s8   <= doe_s7 - 18'(p1460_s7[36:29]) + 18'(p36524_s7[36:34])
				- 18'(p146096_s7[36]);
			doe_s8 <= doe_s7;
			era_s8 <= era_s7;
			wd_s8  <= wd_s7;

			p365_s9 <= t_s8 * R_365;
			doe_s9  <= doe_s8;
			era_s9  <= era_s8;
			wd_s9   <= wd_s8;

			yoe_s10 <= p365_s9[35:27];
			doe_s10 <= doe_s9;
			era_s10 <= era_s9;
			wd_s10  <= wd_s9;

			p100_s11 <= yoe_s10 * R_100;
			y365_s11 <= 18'(yoe_s10) * 18'd365 + 18'(yoe_s10[8:2]);
			yoe_s11  <= yoe_s10;
			doe_s11  <= doe_s10;
			era_s11  <= era_s10;
			wd_s11   <= wd_s10;

			doy_s12 <= 9'(doe_s11 - y365_s11 + 18'(p100_s11[18:16]));
			yoe_s12 <= yoe_s11;
			era_s12 <= era_s11;
			wd_s12  <= wd_s11;

			pmp_s13 <= (12'(doy_s12) * 12'd5 + 12'd2) * R_153;
			doy_s13 <= doy_s12;
			yoe_s13 <= yoe_s12;
			era_s13 <= era_s12;
			wd_s13  <= wd_s12;

			mp_s14  <= pmp_s13[23:20];
			doy_s14 <= doy_s13;
			yoe_s14 <= yoe_s13;
			era_s14 <= era_s13;
			wd_s14  <= wd_s13;

			// january and february close the march-based year and belong to the next one
			date_s15.year         <= 14'(15'(era_s14) * 15'd400 + 15'(yoe_s14) + 15'(jf_n)
				- 15'd400);
			date_s15.month        <= jf_n ? (mp_s14 - MP_JAN) : (mp_s14 + 4'd2);
			date_s15.day_of_month <= 5'(doy_s14 - mstart(mp_s14) + 9'd1);
			date_s15.weekday      <= wd_s14;
			date_s15.day_of_year  <= jf_n ? (doy_s14 - 9'd306)
				: (doy_s14 + 9'd59 + 9'(leap_n));
		end
	end

	assign date = date_s15;

endmodule

// File: rtl/core/epoch_seconds_to_calendar.sv
// throughput: one word per cycle while the result is not stalled,
// every stage is a register of the 15-stage pipe
// a stalled result holds the whole pipe, and the input stalls with it
// reset clears the stage valid bits only, data registers are not reset
module epoch_seconds_to_calendar import ecal_pkg::*; #(
	parameter int MAX_YEAR = MAX_YEAR_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [39:0] epoch_seconds,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               valid_res,
	output logic [13:0]        year,
	output logic [3:0]         month,
	output logic [4:0]         day_of_month,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second,
	output logic [2:0]         weekday,
	output logic [8:0]         day_of_year
);

	// day index of 1 january after the last year, counted from 0000-03-01
	localparam longint ZEND = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400
		+ 306;
	localparam longint SECS_LO_L = -longint'(719528) * 86400;
	localparam longint SECS_HI_L = (ZEND + 60) * 86400 - 1 + SECS_LO_L;
	localparam logic signed [39:0] SECS_LO = 40'(SECS_LO_L);
	localparam logic signed [39:0] SECS_HI = 40'(SECS_HI_L);

	// 86400 = 128 * 675: shift out 128, then divide by 675
	localparam logic [32:0] R_675 = 33'(((64'd1 << 42) + 64'd674) / 64'd675);

	logic               adv;
	logic [NUM_STG:1]   pipe_vld_q;
	logic [NUM_STG:1]   ok_q;
	logic               ok_n;
	logic [38:0]        u_s1;
	logic [31:0]        q1_s2;
	logic [6:0]         r1_s2;
	logic [64:0]        p675_s2;
	logic [DAYS_W-1:0]  days_n;
	logic [DAYS_W-1:0]  days_s3;
	logic [SOD_W-1:0]   sod_s3;
	date_t              date;
	tod_t               tod;

	assign adv      = !(pipe_vld_q[NUM_STG] && out_stall);
	assign in_stall = !adv;
	assign ok_n     = (epoch_seconds >= SECS_LO) && (epoch_seconds <= SECS_HI);
	assign days_n   = p675_s2[63:42];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_vld_q <= '0;
		end else if (adv) begin
			pipe_vld_q <= {pipe_vld_q[NUM_STG-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_q <= {ok_q[NUM_STG-1:1], ok_n};

			// seconds counted from 0000-01-01 00:00:00
			u_s1 <= 39'(epoch_seconds - SECS_LO);

			q1_s2   <= u_s1[38:7];
			r1_s2   <= u_s1[6:0];
			p675_s2 <= u_s1[38:7] * R_675;

			days_s3 <= days_n;
			sod_s3  <= {10'(q1_s2 - 32'(days_n) * 32'd675), r1_s2};
		end
	end

	ecal_date u_date (
		.clk  (clk),
		.adv  (adv),
		.days (days_s3),
		.date (date)
	);

	ecal_tod u_tod (
		.clk (clk),
		.adv (adv),
		.sod (sod_s3),
		.tod (tod)
	);

	// out of range years give all-zero fields
	assign out_valid    = pipe_vld_q[NUM_STG];
	assign valid_res    = ok_q[NUM_STG];
	assign year         = valid_res ? date.year : '0;
	assign month        = valid_res ? date.month : '0;
	assign day_of_month = valid_res ? date.day_of_month : '0;
	assign weekday      = valid_res ? date.weekday : '0;
	assign day_of_year  = valid_res ? date.day_of_year : '0;
	assign hour         = valid_res ? tod.hour : '0;
	assign minute       = valid_res ? tod.minute : '0;
	assign second       = valid_res ? tod.second : '0;

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> (year <= MAX_YEAR) && (month <= 4'd11)
			&& (day_of_month != 5'd0) && (day_of_year <= 9'd365))
		else $error("date field out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59)
			&& (weekday <= 3'd6))
		else $error("time field out of range");

	a_jan_yday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res && (month == 4'd0)
			|-> (10'(day_of_year) + 10'd1 == 10'(day_of_month)))
		else $error("day of year disagrees with january date");

	a_late_yday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res && (month >= 4'd2)
			|-> (10'(day_of_year) >= 10'(day_of_month) + 10'd58))
		else $error("day of year too small for month");

endmodule

// File: bench/ecal_date_check.sv
module ecal_date_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [39:0] epoch_seconds,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               valid_res,
	input  logic [13:0]        year,
	input  logic [3:0]         month,
	input  logic [4:0]         day_of_month,
	input  logic [4:0]         hour,
	input  logic [5:0]         minute,
	input  logic [5:0]         second,
	input  logic [2:0]         weekday,
	input  logic [8:0]         day_of_year,
	output int                 fail_count,
	output int                 words_waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint LAST_YEAR     = 9999;
	localparam longint DAY_SECS      = 86400;
	localparam longint ERA_DAYS      = 146097;
	localparam longint CIVIL_OFFSET  = 719468;

	typedef struct packed {
		logic        valid_res;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [2:0]  weekday;
		logic [8:0]  day_of_year;
	} cal_word_t;

	cal_word_t due_dates[$];

	initial begin
		fail_count = 0;
		words_waiting = 0;
	end

	function automatic cal_word_t civil_from_epoch(input logic signed [39:0] secs_in);
		cal_word_t w;
		longint secs, days, sod, z, era, doe, yoe, y, doy_m, mp, d, m, wd, yday;
		bit leap;
		secs = secs_in;
		days = secs / DAY_SECS;
		sod  = secs % DAY_SECS;
		// floor division so pre-1970 times land on the right day
		if (sod < 0) begin
			sod += DAY_SECS;
			days -= 1;
		end
		z     = days + CIVIL_OFFSET;
		era   = (z >= 0 ? z : z - (ERA_DAYS - 1)) / ERA_DAYS;
		doe   = z - era * ERA_DAYS;
		yoe   = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		y     = yoe + era * 400;
		doy_m = doe - (365 * yoe + yoe / 4 - yoe / 100);
		// month index within the march-based year
		mp    = (5 * doy_m + 2) / 153;
		d     = doy_m - (153 * mp + 2) / 5 + 1;
		m     = (mp < 10) ? mp + 2 : mp - 10;
		if (m <= 1)
			y += 1;
		wd = (days + 4) % 7;
		if (wd < 0)
			wd += 7;
		w = '0;
		if (y < 0 || y > LAST_YEAR)
			return w;
		case (m)
			0:  yday = 0;
			1:  yday = 31;
			2:  yday = 59;
			3:  yday = 90;
			4:  yday = 120;
			5:  yday = 151;
			6:  yday = 181;
			7:  yday = 212;
			8:  yday = 243;
			9:  yday = 273;
			10: yday = 304;
			default: yday = 334;
		endcase
		yday = yday + d - 1;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		if (m >= 2 && leap)
			yday += 1;
		w.valid_res    = 1'b1;
		w.year         = y[13:0];
		w.month        = m[3:0];
		w.day_of_month = d[4:0];
		w.hour         = 5'(sod / 3600);
		w.minute       = 6'((sod % 3600) / 60);
		w.second       = 6'(sod % 60);
		w.weekday      = wd[2:0];
		w.day_of_year  = yday[8:0];
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [13:0] got, input logic [13:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	always @(posedge clk) begin : watch
		cal_word_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				due_dates.push_back(civil_from_epoch(epoch_seconds));
			if (out_valid && !out_stall) begin
				if (due_dates.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = due_dates.pop_front();
					check_field("valid_res", valid_res, want.valid_res);
					check_field("year", year, want.year);
					check_field("month", month, want.month);
					check_field("day_of_month", day_of_month, want.day_of_month);
					check_field("hour", hour, want.hour);
					check_field("minute", minute, want.minute);
					check_field("second", second, want.second);
					check_field("weekday", weekday, want.weekday);
					check_field("day_of_year", day_of_year, want.day_of_year);
				end
			end
			words_waiting = due_dates.size();
		end
	end

endmodule

// File: bench/tb_epoch_seconds_to_calendar.sv
module tb_epoch_seconds_to_calendar;
	timeunit 1ns;
	timeprecision 1ps;

	import ecal_pkg::NUM_STG;

	localparam longint FIRST_VALID_SECS = -64'sd62167219200;
	localparam longint VALID_SPAN_SECS  = 64'sd315569520000;
	localparam longint MIN_SECS         = -64'sd549755813888;
	localparam longint MAX_SECS         = 64'sd549755813887;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [39:0] epoch_seconds = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               valid_res;
	logic [13:0]        year;
	logic [3:0]         month;
	logic [4:0]         day_of_month;
	logic [4:0]         hour;
	logic [5:0]         minute;
	logic [5:0]         second;
	logic [2:0]         weekday;
	logic [8:0]         day_of_year;

	int fail_count;
	int words_waiting;
	int send_idle_pct = 0;
	int stall_pct = 0;

	// leap days, year ends, century rules, range limits and extremes of the field
	longint corner_secs [23] = '{
		0, -1, 1, 86399, 86400, -86400, -86401,
		94694399,                  // 1972-12-31 23:59:59
		951782400,                 // 2000-02-29
		978307199,                 // 2000-12-31 23:59:59
		-64'sd2203891200,          // 1900-03-01
		-64'sd2203891201,          // 1900-02-28 23:59:59
		64'sd4107542400,           // 2100-03-01
		-64'sd62167219200,         // first second of year 0
		-64'sd62167219201,         // year -1
		-64'sd62162121600,         // year 0 feb 29
		64'sd253402300799,         // last second of 9999
		64'sd253402300800,         // year 10000
		-64'sd549755813888, 64'sd549755813887,
		64'sd2147483647, -64'sd2147483648, -64'sd2147483649
	};

	always #5 clk = ~clk;

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	epoch_seconds_to_calendar dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.epoch_seconds(epoch_seconds),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.valid_res    (valid_res),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.weekday      (weekday),
		.day_of_year  (day_of_year)
	);

	ecal_date_check checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.epoch_seconds(epoch_seconds),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.valid_res    (valid_res),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.weekday      (weekday),
		.day_of_year  (day_of_year),
		.fail_count   (fail_count),
		.words_waiting(words_waiting)
	);

	// days from 1970-01-01 to january 1 of the given year
	function automatic longint year_start_days(input longint yr);
		longint y1, era, yoe;
		y1  = yr - 1;
		era = (y1 >= 0 ? y1 : y1 - 399) / 400;
		yoe = y1 - era * 400;
		return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + 306 - 719468;
	endfunction

	function automatic logic signed [39:0] random_secs();
		longint unsigned r;
		longint days, offs;
		int pick;
		r    = {$urandom(), $urandom()};
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return 40'(FIRST_VALID_SECS + longint'(r % VALID_SPAN_SECS));
		if (pick < 70) begin
			// around new year, and around feb 28 / 29 / mar 1
			days = year_start_days($urandom_range(0, 10000));
			if ($urandom_range(0, 1))
				days += $urandom_range(57, 60);
			if ($urandom_range(0, 1))
				offs = longint'($urandom_range(0, 2)) - 1;
			else
				offs = longint'($urandom_range(0, 345600)) - 172800;
			return 40'(days * 86400 + offs);
		end
		if (pick < 85)
			return r[39:0];
		case ($urandom_range(0, 2))
			0:       return 40'(MIN_SECS + longint'(r % 1000));
			1:       return 40'(MAX_SECS - longint'(r % 1000));
			default: return 40'(longint'(r % 2000) - 1000);
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic push_word(input logic signed [39:0] secs);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		epoch_seconds <= secs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (corner_secs[i])
			push_word(40'(corner_secs[i]));
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 79; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 79; end
				default: begin send_idle_pct = 31; stall_pct = 31; end
			endcase
			repeat (150)
				push_word(random_secs());
		end
		in_valid <= 1'b0;
		while (words_waiting != 0)
			@(negedge clk);
		repeat (NUM_STG + 5) @(negedge clk);
		if (fail_count == 0)
			$display("tb_epoch_seconds_to_calendar OK");
		else
			$display("tb_epoch_seconds_to_calendar NOT OK");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_epoch_seconds_to_calendar NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/ecal_pkg.sv
rtl/core/ecal_tod.sv
rtl/core/ecal_date.sv
rtl/core/epoch_seconds_to_calendar.sv
bench/ecal_date_check.sv
bench/tb_epoch_seconds_to_calendar.sv
